FILE: rtl/evd_pkg.sv
package evd_pkg;

   localparam int ENERGY_SUM_WORDS = 4;
   localparam int QDC_SUM_WORDS    = 8;

   localparam logic [4:0] ENERGY_SUM_COUNT = 5'(ENERGY_SUM_WORDS);
   localparam logic [4:0] QDC_SUM_COUNT    = 5'(QDC_SUM_WORDS);

   localparam logic [4:0] HDR_LEN_ESUM = 5'd8;
   localparam logic [4:0] HDR_LEN_QDC  = 5'd12;
   localparam logic [4:0] HDR_LEN_BOTH = 5'd16;

   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_ESUM   = 3'd1;
   localparam logic [2:0] KIND_QDC    = 3'd2;
   localparam logic [2:0] KIND_TRACE  = 3'd3;
   localparam logic [2:0] KIND_ERROR  = 3'd4;

   typedef enum logic [4:0] {
      PH_HDR   = 5'b00001,
      PH_ESUM  = 5'b00010,
      PH_QDC   = 5'b00100,
      PH_TRACE = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [11:0]        source_address;
      logic [4:0]         header_length;
      logic [12:0]        channel_length;
      logic               overflow_flag;
      logic               finish_flag;
      logic signed [63:0] event_time;
      logic [15:0]        energy;
      logic [15:0]        trace_length;
   } rsp_head_type;

   typedef struct packed {
      logic [31:0] item_value;
      logic [15:0] item_index;
      logic        last_of_event;
   } rsp_item_type;

   typedef struct packed {
      logic         any;
      logic         pair;
      rsp_head_type head;
      rsp_item_type lo;
      rsp_item_type hi;
   } decode_type;

endpackage

FILE: rtl/evd_parser.sv
module evd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [31:0]         word,
   input  logic                end_of_event,
   output evd_pkg::decode_type dec
);
   import evd_pkg::*;

   localparam logic [2:0] POS_SIZE = 3'd0;
   localparam logic [2:0] POS_W1   = 3'd1;
   localparam logic [2:0] POS_W2   = 3'd2;
   localparam logic [2:0] POS_W3   = 3'd3;
   localparam logic [2:0] POS_W4   = 3'd4;

   phase_type   phase_ff, phase_in;
   logic [2:0]  word_pos_ff, word_pos_in;
   logic [31:0] word1_ff, word1_in;
   logic [31:0] word4_ff, word4_in;
   logic [63:0] time_ff, time_in;
   logic [15:0] group_ff, group_in;
   logic        skip_ff, skip_in;

   logic [31:0] head_w4;
   logic [4:0]  hl;
   logic [12:0] cl;
   logic [14:0] tw;
   logic [63:0] ts_diff;
   logic [4:0]  sum_count;
   logic [16:0] group_next;
   phase_type   nx;
   logic        fin;

   function automatic phase_type follow_phase(phase_type after, logic [4:0] len,
                                              logic trace_nz);
      phase_type res;
      res = PH_DONE;
      if (after == PH_HDR && (len inside {HDR_LEN_ESUM, HDR_LEN_BOTH})) begin
         res = PH_ESUM;
      end else if (after == PH_HDR && len == HDR_LEN_QDC) begin
         res = PH_QDC;
      end else if (after == PH_ESUM && len == HDR_LEN_BOTH) begin
         res = PH_QDC;
      end else if (after != PH_TRACE && trace_nz) begin
         res = PH_TRACE;
      end
      return res;
   endfunction

   assign hl         = word1_ff[16:12];
   assign cl         = word1_ff[29:17];
   assign group_next = {1'b0, group_ff} + 17'd1;
   assign ts_diff    = {15'd0, word[15:0], time_ff[31:0], 1'b0} - {63'd0, word[30]};

   always_comb begin
      phase_in    = phase_ff;
      word_pos_in = word_pos_ff;
      word1_in    = word1_ff;
      word4_in    = word4_ff;
      time_in     = time_ff;
      group_in    = group_ff;
      skip_in     = skip_ff;
      head_w4     = word4_ff;
      nx          = phase_ff;
      fin         = 1'b0;
      sum_count   = (phase_ff == PH_ESUM) ? ENERGY_SUM_COUNT : QDC_SUM_COUNT;
      dec         = '0;

      if (phase_ff == PH_HDR && word_pos_ff == POS_W4) begin
         head_w4 = word;
      end
      tw = head_w4[31:17];

      if (!skip_ff) begin
         case (phase_ff)
            PH_HDR: begin
               case (word_pos_ff)
                  POS_SIZE: begin
                  end
                  POS_W1: begin
                     word1_in = word;
                     word4_in = '0;
                  end
                  POS_W2: time_in = {32'd0, word};
                  POS_W3: time_in = {ts_diff[49:0], word[29:16]};
                  default: begin
                     word4_in = word;
                     dec.any  = 1'b1;
                     if ({8'd0, hl} == {3'd0, cl}) begin
                        dec.lo.last_of_event = 1'b1;
                        nx = PH_DONE;
                     end else if ({3'd0, cl} != {11'd0, hl} + {1'b0, tw}) begin
                        dec.head.kind        = KIND_ERROR;
                        dec.lo.last_of_event = 1'b1;
                        nx = PH_DONE;
                     end else begin
                        nx = follow_phase(PH_HDR, hl, tw != '0);
                        dec.lo.last_of_event = (nx == PH_DONE);
                     end
                     phase_in = nx;
                     group_in = '0;
                     if (nx == PH_DONE) begin
                        skip_in = 1'b1;
                     end
                  end
               endcase
               if (word_pos_ff < POS_W4) begin
                  word_pos_in = word_pos_ff + 3'd1;
               end
            end
            PH_ESUM, PH_QDC: begin
               if (group_next >= {12'd0, sum_count}) begin
                  nx = follow_phase(phase_ff, hl, tw != '0);
               end
               dec.any              = 1'b1;
               dec.head.kind        = (phase_ff == PH_ESUM) ? KIND_ESUM : KIND_QDC;
               dec.lo.item_value    = word;
               dec.lo.item_index    = group_ff;
               dec.lo.last_of_event = (nx == PH_DONE);
               if (nx != phase_ff) begin
                  phase_in = nx;
                  group_in = '0;
                  if (nx == PH_DONE) begin
                     skip_in = 1'b1;
                  end
               end else begin
                  group_in = group_next[15:0];
               end
            end
            PH_TRACE: begin
               fin                  = group_next >= {2'd0, tw};
               dec.any              = 1'b1;
               dec.pair             = 1'b1;
               dec.head.kind        = KIND_TRACE;
               dec.lo.item_value    = {16'd0, word[15:0]};
               dec.lo.item_index    = {group_ff[14:0], 1'b0};
               dec.hi.item_value    = {16'd0, word[31:16]};
               dec.hi.item_index    = {group_ff[14:0], 1'b1};
               dec.hi.last_of_event = fin;
               if (fin) begin
                  phase_in = PH_DONE;
                  group_in = '0;
                  skip_in  = 1'b1;
               end else begin
                  group_in = group_next[15:0];
               end
            end
            default: skip_in = 1'b1;
         endcase
      end

      dec.head.source_address = word1_ff[11:0];
      dec.head.header_length  = word1_ff[16:12];
      dec.head.channel_length = word1_ff[29:17];
      dec.head.overflow_flag  = word1_ff[30];
      dec.head.finish_flag    = word1_ff[31];
      dec.head.event_time     = time_ff;
      dec.head.energy         = head_w4[15:0];
      dec.head.trace_length   = head_w4[31:16];

      if (end_of_event) begin
         phase_in    = PH_HDR;
         word_pos_in = POS_SIZE;
         word1_in    = '0;
         word4_in    = '0;
         time_in     = '0;
         group_in    = '0;
         skip_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         word_pos_ff <= POS_SIZE;
         word1_ff    <= '0;
         word4_ff    <= '0;
         time_ff     <= '0;
         group_ff    <= '0;
         skip_ff     <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         word_pos_ff <= word_pos_in;
         word1_ff    <= word1_in;
         word4_ff    <= word4_in;
         time_ff     <= time_in;
         group_ff    <= group_in;
         skip_ff     <= skip_in;
      end
   end

endmodule

FILE: rtl/evd_out_stage.sv
module evd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  evd_pkg::decode_type   dec,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output evd_pkg::rsp_head_type head,
   output evd_pkg::rsp_item_type item
);
   import evd_pkg::*;

   logic         valid_ff, valid_in;
   logic         pair_ff, pair_in;
   rsp_head_type head_ff, head_in;
   rsp_item_type cur_ff, cur_in;
   rsp_item_type hi_ff, hi_in;
   logic         rsp_transfer;

   assign rsp_transfer = valid_ff && !rsp_stall;
   assign out_free     = !valid_ff || (rsp_transfer && !pair_ff);

   always_comb begin
      valid_in = valid_ff;
      pair_in  = pair_ff;
      head_in  = head_ff;
      cur_in   = cur_ff;
      hi_in    = hi_ff;
      if (rsp_transfer && pair_ff) begin
         cur_in  = hi_ff;
         pair_in = 1'b0;
      end else if (load) begin
         valid_in = dec.any;
         pair_in  = dec.pair;
         head_in  = dec.head;
         cur_in   = dec.lo;
         hi_in    = dec.hi;
      end else if (rsp_transfer) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pair_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pair_ff  <= pair_in;
      end
      head_ff <= head_in;
      cur_ff  <= cur_in;
      hi_ff   <= hi_in;
   end

   assign rsp_valid = valid_ff;
   assign head      = head_ff;
   assign item      = cur_ff;

endmodule

FILE: rtl/digitizer_event_word_decoder.sv
// a word accepted into the input register is decoded and registered in the result stage once that stage is free
// throughput: one word per cycle while the result side does not stall; a trace word holds
//   the result side for one result per 16-bit sample, set by the single result stage
// reset: synchronous, active high; clears the parser to expect the size word
//   and empties the input and result registers
module digitizer_event_word_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_word,
   input  logic               req_end_of_event,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [11:0]        rsp_source_address,
   output logic [4:0]         rsp_header_length,
   output logic [12:0]        rsp_channel_length,
   output logic               rsp_overflow_flag,
   output logic               rsp_finish_flag,
   output logic signed [63:0] rsp_event_time,
   output logic [15:0]        rsp_energy,
   output logic [15:0]        rsp_trace_length,
   output logic [31:0]        rsp_item_value,
   output logic [15:0]        rsp_item_index,
   output logic               rsp_last_of_event
);
   import evd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [31:0]  in_word_ff;
   logic         in_eoe_ff;
   logic         req_transfer;
   logic         out_free;
   logic         advance;
   decode_type   dec;
   rsp_head_type head;
   rsp_item_type item;

   assign req_transfer = req_valid && !req_stall;
   assign advance      = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_transfer) begin
         in_word_ff <= req_word;
         in_eoe_ff  <= req_end_of_event;
      end
   end

   evd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .word         (in_word_ff),
      .end_of_event (in_eoe_ff),
      .dec          (dec)
   );

   evd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .dec       (dec),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head),
      .item      (item)
   );

   assign rsp_kind           = head.kind;
   assign rsp_source_address = head.source_address;
   assign rsp_header_length  = head.header_length;
   assign rsp_channel_length = head.channel_length;
   assign rsp_overflow_flag  = head.overflow_flag;
   assign rsp_finish_flag    = head.finish_flag;
   assign rsp_event_time     = head.event_time;
   assign rsp_energy         = head.energy;
   assign rsp_trace_length   = head.trace_length;
   assign rsp_item_value     = item.item_value;
   assign rsp_item_index     = item.item_index;
   assign rsp_last_of_event  = item.last_of_event;

endmodule

FILE: rtl/evd_checker.sv
module evd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [31:0]        req_word,
   input logic               req_end_of_event,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_kind,
   input logic [11:0]        rsp_source_address,
   input logic [4:0]         rsp_header_length,
   input logic [12:0]        rsp_channel_length,
   input logic               rsp_overflow_flag,
   input logic               rsp_finish_flag,
   input logic signed [63:0] rsp_event_time,
   input logic [15:0]        rsp_energy,
   input logic [15:0]        rsp_trace_length,
   input logic [31:0]        rsp_item_value,
   input logic [15:0]        rsp_item_index,
   input logic               rsp_last_of_event
);
   import evd_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_value)
         && $stable(rsp_item_index) && $stable(rsp_kind))
      else $error("stalled result changed");

   // length error closes the event and carries no item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
         rsp_last_of_event && rsp_item_value == '0 && rsp_item_index == '0)
      else $error("bad length error result");

   // trace samples are 16 bits and the sample that closes the event has an odd index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_TRACE |->
         rsp_item_value[31:16] == '0 && (rsp_item_index[0] || !rsp_last_of_event))
      else $error("bad trace sample result");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind digitizer_event_word_decoder evd_checker u_evd_checker (.*);
